// ===== src/laser_scan_average_to_points_assert.svh =====
// Assertion macros shared by the laser scan averaging RTL.
// Expects aclk and aresetn in the including module.
`ifndef LASER_SCAN_AVERAGE_TO_POINTS_ASSERT_SVH
`define LASER_SCAN_AVERAGE_TO_POINTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LSA_ASSERT(lbl, expr) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    (expr)) else $error("lsa assertion failed");
`define LSA_IMPLY(lbl, ante, cons) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) (ante) |-> (cons)) else $error("lsa assertion failed");
`define LSA_NEXT(lbl, ante, cons) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) (ante) |=> (cons)) else $error("lsa assertion failed");
`else
`define LSA_ASSERT(lbl, expr)
`define LSA_IMPLY(lbl, ante, cons)
`define LSA_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/lsa_pkg.sv =====
// Shared types and constants for the laser scan averaging block.
// No dependencies.
package lsa_pkg;

    localparam int BEAM_W   = 10;
    localparam int RANGE_W  = 16;
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 5;
    localparam int NUM_W    = 21;
    localparam int RECIP_W  = 22;
    localparam int RECIP_SH = 21;
    localparam int ANG_W    = 16;
    localparam int X_W      = 18;
    localparam int Y_W      = 17;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [15:0] MEAN_MAX = 16'hFFFF;

    // quarter-wave sine polynomial, Q14
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [14:0] SIN_C1  = 15'd25736;
    localparam logic [13:0] SIN_C2  = 14'd10512;
    localparam logic [10:0] SIN_C3  = 11'd1160;
    localparam logic [13:0] ROUND_HALF = 14'd8192;

    // floor(2^21 / count); the divider corrects the one-low case
    localparam logic [RECIP_W-1:0] RECIP [32] = '{
        22'd0,      22'd2097152, 22'd1048576, 22'd699050,
        22'd524288, 22'd419430,  22'd349525,  22'd299593,
        22'd262144, 22'd233016,  22'd209715,  22'd190650,
        22'd174762, 22'd161319,  22'd149796,  22'd139810,
        22'd131072, 22'd123361,  22'd116508,  22'd110376,
        22'd104857, 22'd99864,   22'd95325,   22'd91180,
        22'd87381,  22'd83886,   22'd80659,   22'd77672,
        22'd74898,  22'd72315,   22'd69905,   22'd67650
    };

    typedef enum logic [CFG_AW-1:0] {
        REG_RANGE_FLOOR   = 3'd0,
        REG_RANGE_CEILING = 3'd1,
        REG_START_ANGLE   = 3'd2,
        REG_ANGLE_STEP    = 3'd3,
        REG_SCANS         = 3'd4,
        REG_MOUNT_OFFSET  = 3'd5,
        REG_REAR_MOUNTED  = 3'd6
    } lsa_reg_t;

    typedef struct packed {
        logic [15:0]        range_floor;
        logic [15:0]        range_ceiling;
        logic signed [15:0] start_angle;
        logic [15:0]        angle_step;
        logic [4:0]         scans_to_average;
        logic [15:0]        mount_offset;
        logic               rear_mounted;
    } lsa_cfg_t;

    // accumulator stage to point pipeline
    typedef struct packed {
        logic              vld;
        logic              ok;
        logic              eos;
        logic [BEAM_W-1:0] beam;
        logic [NUM_W-1:0]  num;
        logic [CNT_W-1:0]  cnt;
        logic [ANG_W-1:0]  ang;
    } lsa_link_t;

    typedef struct packed {
        logic              vld;
        logic              ok;
        logic              eos;
        logic [BEAM_W-1:0] beam;
    } lsa_meta_t;

endpackage

// ===== src/laser_scan_average_to_points.sv =====
// Laser scan averaging with conversion of the mean ranges to x/y points.
// Input beat: one range sample of one beam, tlast on the last beam of a scan.
// Each sample strictly between range_floor and range_ceiling adds to its
// beam's sum and count. During the final scan of scans_to_average scans,
// each beam beat gives one output beat: the mean range turned into x/y mm
// (tuser[0] is 0 and x/y are 0 when the beam has no valid sample). Later
// scans are consumed and dropped until the next reset.
// Throughput: one beat per cycle while m_tready keeps up and no RAM clear
// runs. Between input accept and m_tvalid lie the registered accumulator
// read/update, divider and sine polynomial multiplier stages.
// Reset: registers take their defaults, and a sweep over all BEAMS addresses
// clears the sum/count RAM; s_tready stays low for that sweep.
// Config writes are taken at any time but belong to idle periods.
// m_tready low while an output beat waits freezes the whole pipeline and
// drops s_tready in the same cycle; nothing is lost or repeated.
// Depends on lsa_pkg, lsa_accum, lsa_point and lsa_ram.
module laser_scan_average_to_points #(
    parameter int BEAMS     = 1024,
    parameter int MAX_SCANS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lsa_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [lsa_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // beam_index[9:0], range_mm[25:10]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // point_beam[9:0], x_mm[27:10], y_mm[44:28]
    output logic [1:0]                    m_tuser,  // point_valid[0], rear_tag[1]
    output logic                          m_tlast
);
    import lsa_pkg::*;

    lsa_cfg_t  cfg_reg, cfg_next;
    lsa_link_t link;
    lsa_meta_t m_meta;
    logic      adv;
    logic [X_W-1:0] m_x;
    logic [Y_W-1:0] m_y;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (lsa_reg_t'(cfg_addr))
                REG_RANGE_FLOOR:   cfg_next.range_floor      = cfg_wdata;
                REG_RANGE_CEILING: cfg_next.range_ceiling    = cfg_wdata;
                REG_START_ANGLE:   cfg_next.start_angle      = $signed(cfg_wdata);
                REG_ANGLE_STEP:    cfg_next.angle_step       = cfg_wdata;
                REG_SCANS:         cfg_next.scans_to_average = cfg_wdata[4:0];
                REG_MOUNT_OFFSET:  cfg_next.mount_offset     = cfg_wdata;
                REG_REAR_MOUNTED:  cfg_next.rear_mounted     = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_floor      <= 16'd0;
            cfg_reg.range_ceiling    <= 16'hFFFF;
            cfg_reg.start_angle      <= 16'sh8000;
            cfg_reg.angle_step       <= 16'd91;
            cfg_reg.scans_to_average <= 5'd10;
            cfg_reg.mount_offset     <= 16'd255;
            cfg_reg.rear_mounted     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lsa_accum #(
        .BEAMS    (BEAMS),
        .MAX_SCANS(MAX_SCANS)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .adv     (adv),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_beam  (s_tdata[9:0]),
        .s_range (s_tdata[25:10]),
        .s_eos   (s_tlast),
        .link    (link)
    );

    lsa_point u_point (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .link   (link),
        .m_ready(m_tready),
        .adv    (adv),
        .m_valid(m_tvalid),
        .m_meta (m_meta),
        .m_x    (m_x),
        .m_y    (m_y)
    );

    assign m_tdata = {3'b000, m_y, m_x, m_meta.beam};
    assign m_tuser = {cfg_reg.rear_mounted, m_meta.ok};
    assign m_tlast = m_meta.eos;

endmodule

// ===== src/lsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lsa_accum.sv =====
// Per-beam sum/count accumulator: scan gating, clearing sweep, RAM update.
// Depends on lsa_pkg, lsa_ram and the assertion header.
`include "laser_scan_average_to_points_assert.svh"
module lsa_accum #(
    parameter int BEAMS     = 1024,
    parameter int MAX_SCANS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsa_pkg::lsa_cfg_t             cfg,
    input  logic                          adv,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsa_pkg::BEAM_W-1:0]    s_beam,
    input  logic [lsa_pkg::RANGE_W-1:0]   s_range,
    input  logic                          s_eos,
    output lsa_pkg::lsa_link_t            link
);
    import lsa_pkg::*;

    localparam int AW = $clog2(BEAMS);
    localparam int SW = $clog2(MAX_SCANS + 1);
    localparam int DW = SUM_W + CNT_W;

    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [SW-1:0] scans_seen_reg, scans_seen_next;
    logic [SW-1:0] target;
    logic          accept, done, emit, in_bounds, range_ok;

    logic              p1_vld_reg, p1_emit_reg, p1_acc_reg, p1_inb_reg, p1_eos_reg;
    logic [BEAM_W-1:0] p1_beam_reg;
    logic [RANGE_W-1:0] p1_range_reg;
    logic              p2_vld_reg, p2_emit_reg, p2_acc_reg, p2_inb_reg, p2_eos_reg;
    logic [BEAM_W-1:0] p2_beam_reg;
    logic [RANGE_W-1:0] p2_range_reg;

    logic          lw_vld_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [DW-1:0] lw_data_reg;

    logic [DW-1:0]    rdata, cur, wr_data;
    logic [AW-1:0]    wr_addr, p2_addr;
    logic             wr_en, acc_we, fwd;
    logic [SUM_W-1:0] cur_sum, sum_new, upd_sum;
    logic [CNT_W-1:0] cur_cnt, cnt_new, upd_cnt;
    logic [SUM_W:0]   sum_add;
    logic [BEAM_W+ANG_W-1:0] ang_prod;

    always_comb begin
        if (cfg.scans_to_average == '0) begin
            target = SW'(1);
        end else if (32'(cfg.scans_to_average) > 32'(MAX_SCANS)) begin
            target = SW'(MAX_SCANS);
        end else begin
            target = SW'(cfg.scans_to_average);
        end
    end

    assign s_tready  = !clearing_reg && adv;
    assign accept    = s_tvalid && s_tready;
    assign done      = scans_seen_reg >= target;
    assign emit      = ({1'b0, scans_seen_reg} + (SW+1)'(1)) == {1'b0, target};
    assign in_bounds = 32'(s_beam) < 32'(BEAMS);
    assign range_ok  = (s_range > cfg.range_floor) && (s_range < cfg.range_ceiling);

    always_comb begin
        scans_seen_next = scans_seen_reg;
        if (accept && !done && s_eos) begin
            scans_seen_next = scans_seen_reg + SW'(1);
        end
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(BEAMS - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            scans_seen_reg <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            lw_vld_reg     <= 1'b0;
        end else begin
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            scans_seen_reg <= scans_seen_next;
            if (adv) begin
                p1_vld_reg <= accept && !done;
                p2_vld_reg <= p1_vld_reg;
            end
            if (acc_we) begin
                lw_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_emit_reg  <= emit;
            p1_acc_reg   <= in_bounds && range_ok;
            p1_inb_reg   <= in_bounds;
            p1_eos_reg   <= s_eos;
            p1_beam_reg  <= s_beam;
            p1_range_reg <= s_range;
            p2_emit_reg  <= p1_emit_reg;
            p2_acc_reg   <= p1_acc_reg;
            p2_inb_reg   <= p1_inb_reg;
            p2_eos_reg   <= p1_eos_reg;
            p2_beam_reg  <= p1_beam_reg;
            p2_range_reg <= p1_range_reg;
        end
        if (acc_we) begin
            lw_addr_reg <= p2_addr;
            lw_data_reg <= wr_data;
        end
    end

    // read is taken on the edge the item moves to p2; the write of the item
    // ahead lands on that same edge, so it is forwarded
    assign p2_addr = AW'(p2_beam_reg);
    assign fwd     = lw_vld_reg && (lw_addr_reg == p2_addr);
    assign cur     = fwd ? lw_data_reg : rdata;
    assign cur_sum = cur[SUM_W-1:0];
    assign cur_cnt = cur[DW-1:SUM_W];
    assign sum_add = {1'b0, cur_sum} + (SUM_W+1)'(p2_range_reg);
    assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign cnt_new = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
    assign upd_sum = p2_acc_reg ? sum_new : cur_sum;
    assign upd_cnt = p2_acc_reg ? cnt_new : cur_cnt;
    assign acc_we  = p2_vld_reg && p2_acc_reg && adv;

    assign wr_en   = clearing_reg || acc_we;
    assign wr_addr = clearing_reg ? clr_addr_reg : p2_addr;
    assign wr_data = clearing_reg ? '0 : {cnt_new, sum_new};

    lsa_ram #(
        .WIDTH(DW),
        .DEPTH(BEAMS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (adv),
        .raddr(AW'(p1_beam_reg)),
        .rdata(rdata)
    );

    assign ang_prod = p2_beam_reg * cfg.angle_step;

    always_comb begin
        link.vld  = p2_vld_reg && p2_emit_reg;
        link.ok   = p2_inb_reg && (upd_cnt != '0);
        link.eos  = p2_eos_reg;
        link.beam = p2_beam_reg;
        link.num  = {1'b0, upd_sum} + NUM_W'(upd_cnt >> 1);
        link.cnt  = upd_cnt;
        link.ang  = $unsigned(cfg.start_angle) + ang_prod[ANG_W-1:0];
    end

    `LSA_IMPLY(a_clear_blocks_input, clearing_reg, !s_tready)
    `LSA_ASSERT(a_scans_bounded, 32'(scans_seen_reg) <= 32'(MAX_SCANS))
    `LSA_NEXT(a_write_recorded, acc_we, lw_vld_reg && lw_addr_reg == $past(p2_addr))

endmodule

// ===== src/lsa_point.sv =====
// Mean division, sine/cosine polynomial and x/y assembly, plus output register.
// Depends on lsa_pkg and the assertion header.
`include "laser_scan_average_to_points_assert.svh"
module lsa_point (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lsa_pkg::lsa_cfg_t           cfg,
    input  lsa_pkg::lsa_link_t          link,
    input  logic                        m_ready,
    output logic                        adv,
    output logic                        m_valid,
    output lsa_pkg::lsa_meta_t          m_meta,
    output logic [lsa_pkg::X_W-1:0]     m_x,
    output logic [lsa_pkg::Y_W-1:0]     m_y
);
    import lsa_pkg::*;

    localparam int STAGES = 6;

    function automatic logic [14:0] fold(input logic [15:0] a);
        logic [14:0] r;
        r = {1'b0, a[13:0]};
        return a[14] ? (QUARTER - r) : r;
    endfunction

    lsa_meta_t meta_reg [STAGES];
    lsa_meta_t out_meta_reg;
    logic      out_vld_reg;
    logic [X_W-1:0] out_x_reg;
    logic [Y_W-1:0] out_y_reg;

    // s1
    logic [NUM_W-1:0] s1_num_reg;
    logic [CNT_W-1:0] s1_cnt_reg;
    logic [ANG_W-1:0] s1_ang_reg;
    // s2
    logic [NUM_W-1:0] s2_q_reg, s2_num_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic [14:0]      s2_ts_reg, s2_tc_reg, s2_t2s_reg, s2_t2c_reg;
    logic             s2_ns_reg, s2_nc_reg;
    // s3
    logic [NUM_W-1:0]       s3_q_reg, s3_num_reg;
    logic [NUM_W+CNT_W-1:0] s3_qc_reg;
    logic [CNT_W-1:0]       s3_cnt_reg;
    logic [14:0]            s3_ts_reg, s3_tc_reg, s3_t2s_reg, s3_t2c_reg;
    logic [10:0]            s3_as_reg, s3_ac_reg;
    logic                   s3_ns_reg, s3_nc_reg;
    // s4
    logic [15:0] s4_mean_reg;
    logic [14:0] s4_ts_reg, s4_tc_reg;
    logic [13:0] s4_bs_reg, s4_bc_reg;
    logic        s4_ns_reg, s4_nc_reg;
    // s5
    logic [15:0] s5_mean_reg, s5_ms_reg, s5_mc_reg;
    logic        s5_ns_reg, s5_nc_reg;
    // s6
    logic [18:0] s6_ps_reg, s6_pc_reg;
    logic        s6_ns_reg, s6_nc_reg;

    logic [RECIP_W-1:0]       recip;
    logic [NUM_W+RECIP_W-1:0] prod_q;
    logic [15:0]              ang_c;
    logic [14:0]              ts, tc;
    logic [29:0]              sq_s, sq_c;
    logic [NUM_W+CNT_W-1:0]   qc;
    logic [25:0]              a_s, a_c;
    logic [NUM_W-1:0]         rem;
    logic [NUM_W:0]           q_fix;
    logic [15:0]              mean;
    logic [28:0]              b_s, b_c;
    logic [14:0]              c_s, c_c;
    logic [29:0]              m_s, m_c;
    logic [32:0]              p_s, p_c;
    logic signed [19:0]       dx, dy, xs, x_fin, y_fin;

    assign adv = !out_vld_reg || m_ready;

    // stage s1: reciprocal multiply, fold angles, square
    assign recip  = RECIP[s1_cnt_reg];
    assign prod_q = s1_num_reg * recip;
    assign ang_c  = s1_ang_reg + 16'(QUARTER);
    assign ts     = fold(s1_ang_reg);
    assign tc     = fold(ang_c);
    assign sq_s   = ts * ts;
    assign sq_c   = tc * tc;

    // stage s2: quotient times count, first polynomial term
    assign qc  = s2_q_reg * s2_cnt_reg;
    assign a_s = SIN_C3 * s2_t2s_reg;
    assign a_c = SIN_C3 * s2_t2c_reg;

    // stage s3: one-step correction of the quotient, second term
    assign rem   = s3_num_reg - s3_qc_reg[NUM_W-1:0];
    assign q_fix = {1'b0, s3_q_reg} + (NUM_W+1)'(rem >= NUM_W'(s3_cnt_reg));
    assign mean  = (q_fix > (NUM_W+1)'(MEAN_MAX)) ? MEAN_MAX : q_fix[15:0];
    assign b_s   = (SIN_C2 - 14'(s3_as_reg)) * s3_t2s_reg;
    assign b_c   = (SIN_C2 - 14'(s3_ac_reg)) * s3_t2c_reg;

    // stage s4: last term
    assign c_s = SIN_C1 - 15'(s4_bs_reg);
    assign c_c = SIN_C1 - 15'(s4_bc_reg);
    assign m_s = c_s * s4_ts_reg;
    assign m_c = c_c * s4_tc_reg;

    // stage s5: scale by mean, round half up on magnitude
    assign p_s = s5_mean_reg * s5_ms_reg + 33'(ROUND_HALF);
    assign p_c = s5_mean_reg * s5_mc_reg + 33'(ROUND_HALF);

    // stage s6: signs, offset, rear mirroring
    assign dx    = s6_nc_reg ? -$signed({1'b0, s6_pc_reg}) : $signed({1'b0, s6_pc_reg});
    assign dy    = s6_ns_reg ? -$signed({1'b0, s6_ps_reg}) : $signed({1'b0, s6_ps_reg});
    assign xs    = $signed({4'b0, cfg.mount_offset}) + dx;
    assign x_fin = cfg.rear_mounted ? -xs : xs;
    assign y_fin = cfg.rear_mounted ? -dy : dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                meta_reg[i] <= '0;
            end
            out_meta_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else if (adv) begin
            meta_reg[0] <= '{vld: link.vld, ok: link.ok, eos: link.eos, beam: link.beam};
            for (int i = 1; i < STAGES; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
            out_meta_reg <= meta_reg[STAGES-1];
            out_vld_reg  <= meta_reg[STAGES-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_num_reg <= link.num;
            s1_cnt_reg <= link.cnt;
            s1_ang_reg <= link.ang;

            s2_q_reg   <= prod_q[RECIP_SH+NUM_W-1:RECIP_SH];
            s2_num_reg <= s1_num_reg;
            s2_cnt_reg <= s1_cnt_reg;
            s2_ts_reg  <= ts;
            s2_tc_reg  <= tc;
            s2_t2s_reg <= sq_s[28:14];
            s2_t2c_reg <= sq_c[28:14];
            s2_ns_reg  <= s1_ang_reg[15];
            s2_nc_reg  <= ang_c[15];

            s3_q_reg   <= s2_q_reg;
            s3_num_reg <= s2_num_reg;
            s3_qc_reg  <= qc;
            s3_cnt_reg <= s2_cnt_reg;
            s3_ts_reg  <= s2_ts_reg;
            s3_tc_reg  <= s2_tc_reg;
            s3_t2s_reg <= s2_t2s_reg;
            s3_t2c_reg <= s2_t2c_reg;
            s3_as_reg  <= a_s[24:14];
            s3_ac_reg  <= a_c[24:14];
            s3_ns_reg  <= s2_ns_reg;
            s3_nc_reg  <= s2_nc_reg;

            s4_mean_reg <= mean;
            s4_ts_reg   <= s3_ts_reg;
            s4_tc_reg   <= s3_tc_reg;
            s4_bs_reg   <= b_s[27:14];
            s4_bc_reg   <= b_c[27:14];
            s4_ns_reg   <= s3_ns_reg;
            s4_nc_reg   <= s3_nc_reg;

            s5_mean_reg <= s4_mean_reg;
            s5_ms_reg   <= m_s[29:14];
            s5_mc_reg   <= m_c[29:14];
            s5_ns_reg   <= s4_ns_reg;
            s5_nc_reg   <= s4_nc_reg;

            s6_ps_reg <= p_s[32:14];
            s6_pc_reg <= p_c[32:14];
            s6_ns_reg <= s5_ns_reg;
            s6_nc_reg <= s5_nc_reg;

            out_x_reg <= meta_reg[STAGES-1].ok ? X_W'(x_fin) : '0;
            out_y_reg <= meta_reg[STAGES-1].ok ? Y_W'(y_fin) : '0;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_meta  = out_meta_reg;
    assign m_x     = out_x_reg;
    assign m_y     = out_y_reg;

    `LSA_IMPLY(a_invalid_point_zero, out_vld_reg && !out_meta_reg.ok, out_x_reg == '0 && out_y_reg == '0)
    `LSA_NEXT(a_stall_holds_point, out_vld_reg && !m_ready, out_vld_reg && $stable(out_meta_reg))
    `LSA_IMPLY(a_empty_output_advances, !out_vld_reg, adv)

endmodule
